// ===== rtl/sha256_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the SHA-256 stream hasher.
// Holds request/response payload structs, hash state type and round tables.
package sha256_pkg;

   typedef enum logic {
      OP_ABSORB = 1'b0,
      OP_FINISH = 1'b1
   } op_type;

   typedef struct packed {
      op_type      operation;
      logic [7:0]  msg_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // Working variables / chain words, element 0 is word a (digest word 0).
   typedef logic [7:0][31:0]  hash_state_type;
   // Message block / schedule window, element 15 is the oldest word.
   typedef logic [15:0][31:0] sched_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;

   localparam hash_state_type INIT_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [0:63][31:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

// ===== rtl/sha256_round.sv =====
`timescale 1ns / 1ps
// One SHA-256 compression round plus one message schedule step.
// Depends on sha256_pkg for the state and schedule types.
module sha256_round (
   input  sha256_pkg::hash_state_type state_cur,
   input  sha256_pkg::sched_type      sched,
   input  logic [31:0]                round_const,
   output sha256_pkg::hash_state_type state_next,
   output logic [31:0]                sched_word
);
   import sha256_pkg::*;

   function automatic logic [31:0] big_sigma0(logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   logic [31:0] pick;
   logic [31:0] vote;
   logic [31:0] t1;
   logic [31:0] t2;

   always_comb begin
      pick = (state_cur[4] & state_cur[5]) ^ (~state_cur[4] & state_cur[6]);
      vote = (state_cur[0] & state_cur[1]) ^ (state_cur[0] & state_cur[2])
           ^ (state_cur[1] & state_cur[2]);
      t1 = state_cur[7] + big_sigma1(state_cur[4]) + pick + round_const + sched[15];
      t2 = big_sigma0(state_cur[0]) + vote;
      state_next[7] = state_cur[6];
      state_next[6] = state_cur[5];
      state_next[5] = state_cur[4];
      state_next[4] = state_cur[3] + t1;
      state_next[3] = state_cur[2];
      state_next[2] = state_cur[1];
      state_next[1] = state_cur[0];
      state_next[0] = t1 + t2;
      // w[t+16] from the window w[t..t+15]
      sched_word = small_sigma1(sched[1]) + sched[6] + small_sigma0(sched[14]) + sched[15];
   end

endmodule

// ===== rtl/sha256_stream_hasher_unit.sv =====
`timescale 1ns / 1ps
// SHA-256 stream hasher, top level.
// Depends on sha256_pkg and sha256_round.
//
// Usage:
//   Requests arrive on req_valid / req_stall / req_payload. An absorb request
//   carries one message byte; a finish request pads the message, runs the
//   last compression(s) and emits the digest.
//   Results leave on rsp_valid / rsp_stall / rsp_payload: eight 32-bit digest
//   words, word_index 0 (most significant) first, last_word set on word 7.
// Timing:
//   An absorb is accepted in ST_IDLE; the 64th byte of a block then runs the
//   rounds (ST_ROUND) and the fold (ST_FOLD) before the next byte is taken,
//   and the rounds all run on the single shared round unit.
//   A finish is accepted in ST_IDLE, then shifts in one pad byte per cycle up
//   to the block end (or to the end of a second block when the length spills
//   into it), plus a round and fold pass per compression, then the eight
//   result words. req_stall is high for the whole of that work.
// Reset:
//   Synchronous, active high. The chain value returns to the initial hash
//   words, the byte count and bit length clear, and the block goes idle.
// Stall:
//   While rsp_stall is high the current digest word holds; the block stays
//   busy until all eight words have been taken, then reloads the initial
//   hash words for the next message.
module sha256_stream_hasher_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sha256_pkg::req_type  req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sha256_pkg::rsp_type  rsp_payload
);
   import sha256_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_FOLD,
      ST_OUTPUT
   } state_type;

   state_type      state_ff, state_in;
   hash_state_type chain_ff, chain_in;
   hash_state_type work_ff, work_in;
   sched_type      block_ff, block_in;
   logic [5:0]     fill_ff, fill_in;
   logic [63:0]    bits_ff, bits_in;
   logic [5:0]     round_ff, round_in;
   logic [2:0]     word_ff, word_in;
   logic           finishing_ff, finishing_in;  // finish request in progress
   logic           first_pad_ff, first_pad_in;  // next pad byte is the 0x80 marker
   logic           spill_ff, spill_in;          // zero fill runs to block end
   logic           final_ff, final_in;          // current block carries the length

   hash_state_type round_state;
   logic [31:0]    round_word;
   logic [7:0]     pad_byte;

   sha256_round u_round (
      .state_cur   (work_ff),
      .sched       (block_ff),
      .round_const (ROUND_K[round_ff]),
      .state_next  (round_state),
      .sched_word  (round_word)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUTPUT);

   always_comb begin
      rsp_payload.digest_word = chain_ff[word_ff];
      rsp_payload.word_index  = word_ff;
      rsp_payload.last_word   = (word_ff == 3'd7);
   end

   // Pick the padding byte: marker, zero fill, or the next length byte.
   always_comb begin
      if (first_pad_ff) begin
         pad_byte = PAD_BYTE;
      end else if (spill_ff || (fill_ff < LEN_START)) begin
         pad_byte = 8'h00;
      end else begin
         pad_byte = bits_ff[63:56];
      end
   end

   always_comb begin
      state_in     = state_ff;
      chain_in     = chain_ff;
      work_in      = work_ff;
      block_in     = block_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      round_in     = round_ff;
      word_in      = word_ff;
      finishing_in = finishing_ff;
      first_pad_in = first_pad_ff;
      spill_in     = spill_ff;
      final_in     = final_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_payload.operation == OP_ABSORB) begin
                  block_in = {block_ff[15][23:0], block_ff[14:0], req_payload.msg_byte};
                  fill_in  = fill_ff + 6'd1;
                  bits_in  = bits_ff + 64'd8;
                  if (fill_ff == 6'd63) begin
                     work_in  = chain_ff;
                     round_in = '0;
                     state_in = ST_ROUND;
                  end
               end else begin
                  finishing_in = 1'b1;
                  first_pad_in = 1'b1;
                  spill_in     = 1'b0;
                  final_in     = 1'b0;
                  state_in     = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            block_in     = {block_ff[15][23:0], block_ff[14:0], pad_byte};
            fill_in      = fill_ff + 6'd1;
            first_pad_in = 1'b0;
            if (first_pad_ff && (fill_ff >= LEN_START)) begin
               spill_in = 1'b1;
            end
            // advance the length shifter on each length byte; it ends at zero
            if (!first_pad_ff && !spill_ff && (fill_ff >= LEN_START)) begin
               bits_in = {bits_ff[55:0], 8'h00};
            end
            if (fill_ff == 6'd63) begin
               final_in = !spill_ff && !first_pad_ff;
               spill_in = 1'b0;
               work_in  = chain_ff;
               round_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            work_in  = round_state;
            block_in = sched_type'({block_ff[14:0], round_word});
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + work_ff[i];
            end
            if (final_ff) begin
               word_in  = '0;
               state_in = ST_OUTPUT;
            end else if (finishing_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_stall) begin
               word_in = word_ff + 3'd1;
               if (word_ff == 3'd7) begin
                  // drop the digest and start a fresh message
                  chain_in     = INIT_HASH;
                  finishing_in = 1'b0;
                  final_in     = 1'b0;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff     <= INIT_HASH;
         fill_ff      <= '0;
         bits_ff      <= '0;
         round_ff     <= '0;
         word_ff      <= '0;
         finishing_ff <= 1'b0;
         first_pad_ff <= 1'b0;
         spill_ff     <= 1'b0;
         final_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         round_ff     <= round_in;
         word_ff      <= word_in;
         finishing_ff <= finishing_in;
         first_pad_ff <= first_pad_in;
         spill_ff     <= spill_in;
         final_ff     <= final_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      block_ff <= block_in;
   end

endmodule
